@@ hdl/prefix_code_stream_decoder_top_macros.svh @@
// Assertion macros for the prefix code stream decoder.
// Used by the top level only; no other dependencies.
`ifndef PREFIX_CODE_STREAM_DECODER_TOP_MACROS_SVH
`define PREFIX_CODE_STREAM_DECODER_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PCSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pcsd assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define PCSD_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("pcsd assertion failed");

`endif

@@ hdl/pcsd_pkg.sv @@
// Shared types and constants of the prefix code stream decoder.
// Used by the controller, the datapath and the top level.
package pcsd_pkg;

  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_MAX_CODE_BITS = 20;
  localparam int DEF_HEADER_BYTES  = 4;

  localparam int INDEX_W   = 8;
  localparam int CODE_W    = 20;
  localparam int LEN_W     = 5;
  localparam int SYM_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 4 * 8;
  localparam int HDR_CNT_W = 3;
  localparam int BIT_CNT_W = 3;
  localparam logic [BIT_CNT_W-1:0] BYTE_TOP_BIT = 3'd7;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  typedef struct packed {
    logic load;
    logic header;
    logic start_byte;
    logic shift;
    logic scan_start;
    logic scan_run;
    logic capture;
    logic next_bit;
    logic flush;
    logic clear_frame;
  } cmd_t;

  typedef struct packed {
    logic hdr_done;
    logic stopped;
    logic overflow;
    logic hit;
    logic miss_done;
    logic out_free;
    logic pend_valid;
    logic bit_zero;
    logic last_flag;
  } status_t;

endpackage

@@ hdl/pcsd_ctrl.sv @@
// Controller of the prefix code stream decoder: sequences load, header,
// bit shift, table scan, emit and flush steps. Depends on pcsd_pkg.
module pcsd_ctrl import pcsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_action_i,
  input  logic    in_last_byte_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SHIFT = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_EMIT  = 6'b001000,
    ST_NEXT  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_action_i == ACT_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (!status_i.hdr_done) begin
            cmd_o.header      = 1'b1;
            cmd_o.clear_frame = in_last_byte_i;
          end else if (status_i.stopped) begin
            cmd_o.clear_frame = in_last_byte_i;
          end else begin
            cmd_o.start_byte = 1'b1;
            state_d          = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (status_i.overflow) begin
          state_d = ST_NEXT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          state_d = ST_EMIT;
        end else if (status_i.miss_done) begin
          state_d = ST_NEXT;
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (status_i.stopped || status_i.bit_zero) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.next_bit = 1'b1;
          state_d        = ST_SHIFT;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.flush       = 1'b1;
          cmd_o.clear_frame = status_i.last_flag;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/pcsd_datapath.sv @@
// Datapath of the prefix code stream decoder: code table memory, valid bits,
// partial code, frame counters, pending result and output register.
// Depends on pcsd_pkg; driven by pcsd_ctrl.
module pcsd_datapath import pcsd_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
  parameter int HEADER_BYTES  = DEF_HEADER_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [INDEX_W-1:0] in_entry_index_i,
  input  logic [CODE_W-1:0]  in_entry_code_i,
  input  logic [LEN_W-1:0]   in_entry_length_i,
  input  logic [SYM_W-1:0]   in_entry_symbol_i,
  input  logic [BYTE_W-1:0]  in_data_byte_i,
  input  logic               in_last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SYM_W-1:0]   out_symbol_o,
  output logic               out_last_of_run_o,
  output logic               out_frame_done_o
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PC_W  = MAX_CODE_BITS;
  localparam int PL_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int CMP_W = (MAX_CODE_BITS > CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam int LC_W  = (PL_W > LEN_W) ? PL_W : LEN_W;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  entry_t             rd_q;
  logic               rd_valid_q;
  logic               rd_pend_q, rd_pend_d;
  logic               rd_last_q, rd_last_d;
  logic [IDX_W-1:0]   scan_addr_q, scan_addr_d;
  logic               issue_done_q, issue_done_d;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;

  logic [PC_W-1:0]      pc_q, pc_d;
  logic [PL_W-1:0]      plen_q, plen_d;
  logic [HDR_CNT_W-1:0] hdr_q, hdr_d;
  logic [COUNT_W-1:0]   target_q, target_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 stopped_q, stopped_d;
  logic [BYTE_W-1:0]    byte_q;
  logic                 last_q;
  logic [BIT_CNT_W-1:0] bit_q, bit_d;

  logic               pend_valid_q, pend_valid_d;
  logic [SYM_W-1:0]   pend_sym_q;
  logic               pend_done_q;

  logic               out_valid_q, out_valid_d;
  logic [SYM_W-1:0]   out_sym_q;
  logic               out_last_q;
  logic               out_done_q;
  logic               push;
  logic               push_last;
  logic               out_free;

  logic [CMP_W-1:0]   mask;
  logic               len_ok;
  logic               code_ok;
  logic               hit;
  logic [COUNT_W-1:0] count_inc;
  logic               done;

  assign wr_en   = cmd_i.load &&
                   ({1'b0, in_entry_index_i} < (INDEX_W + 1)'(TABLE_ENTRIES));
  assign wr_addr = in_entry_index_i[IDX_W-1:0];
  assign rd_en   = cmd_i.scan_run && !issue_done_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{bits: in_entry_code_i, len: in_entry_length_i,
                        sym: in_entry_symbol_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q       <= mem[scan_addr_q];
      rd_valid_q <= valid_q[scan_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    scan_addr_d  = scan_addr_q;
    issue_done_d = issue_done_q;
    rd_last_d    = rd_last_q;
    rd_pend_d    = rd_en;
    if (cmd_i.scan_start) begin
      scan_addr_d  = '0;
      issue_done_d = 1'b0;
      rd_pend_d    = 1'b0;
    end else if (rd_en) begin
      rd_last_d    = (scan_addr_q == IDX_W'(TABLE_ENTRIES - 1));
      issue_done_d = rd_last_d;
      scan_addr_d  = scan_addr_q + 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < CMP_W; k++) begin
      mask[k] = (k < int'(rd_q.len));
    end
  end

  assign len_ok  = (rd_q.len != '0) &&
                   (LC_W'(rd_q.len) <= LC_W'(MAX_CODE_BITS)) &&
                   (LC_W'(rd_q.len) == LC_W'(plen_q));
  assign code_ok = ((CMP_W'(rd_q.bits) & mask) == CMP_W'(pc_q));
  assign hit     = rd_pend_q && rd_valid_q && len_ok && code_ok;

  assign count_inc = count_q + 1'b1;
  assign done      = (target_q != '0) && (count_inc == target_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    pc_d         = pc_q;
    plen_d       = plen_q;
    hdr_d        = hdr_q;
    target_d     = target_q;
    count_d      = count_q;
    stopped_d    = stopped_q;
    bit_d        = bit_q;
    pend_valid_d = pend_valid_q;
    push         = 1'b0;
    push_last    = 1'b0;
    if (cmd_i.header) begin
      target_d = {target_q[COUNT_W-BYTE_W-1:0], in_data_byte_i};
      hdr_d    = hdr_q + 1'b1;
    end
    if (cmd_i.start_byte) begin
      bit_d = BYTE_TOP_BIT;
    end
    if (cmd_i.shift) begin
      if (status_o.overflow) begin
        pc_d   = '0;
        plen_d = '0;
      end else begin
        pc_d   = PC_W'({pc_q, byte_q[bit_q]});
        plen_d = plen_q + 1'b1;
      end
    end
    if (cmd_i.capture) begin
      pc_d         = '0;
      plen_d       = '0;
      count_d      = count_inc;
      stopped_d    = stopped_q || done;
      push         = pend_valid_q;
      pend_valid_d = 1'b1;
    end
    if (cmd_i.next_bit) begin
      bit_d = bit_q - 1'b1;
    end
    if (cmd_i.flush) begin
      push         = pend_valid_q;
      push_last    = 1'b1;
      pend_valid_d = 1'b0;
    end
    if (cmd_i.clear_frame) begin
      pc_d      = '0;
      plen_d    = '0;
      hdr_d     = '0;
      target_d  = '0;
      count_d   = '0;
      stopped_d = 1'b0;
    end
  end

  assign out_valid_d = push || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
      scan_addr_q  <= '0;
      issue_done_q <= 1'b0;
      pc_q         <= '0;
      plen_q       <= '0;
      hdr_q        <= '0;
      target_q     <= '0;
      count_q      <= '0;
      stopped_q    <= 1'b0;
      bit_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_pend_q    <= rd_pend_d;
      rd_last_q    <= rd_last_d;
      scan_addr_q  <= scan_addr_d;
      issue_done_q <= issue_done_d;
      pc_q         <= pc_d;
      plen_q       <= plen_d;
      hdr_q        <= hdr_d;
      target_q     <= target_d;
      count_q      <= count_d;
      stopped_q    <= stopped_d;
      bit_q        <= bit_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_byte) begin
      byte_q <= in_data_byte_i;
      last_q <= in_last_byte_i;
    end
    if (cmd_i.capture) begin
      pend_sym_q  <= rd_q.sym;
      pend_done_q <= done;
    end
    if (push) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= push_last;
      out_done_q <= pend_done_q;
    end
  end

  assign status_o.hdr_done   = (hdr_q >= HDR_CNT_W'(HEADER_BYTES));
  assign status_o.stopped    = stopped_q;
  assign status_o.overflow   = (plen_q >= PL_W'(MAX_CODE_BITS));
  assign status_o.hit        = hit;
  assign status_o.miss_done  = rd_pend_q && rd_last_q && !hit;
  assign status_o.out_free   = out_free;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.bit_zero   = (bit_q == '0);
  assign status_o.last_flag  = last_q;

  assign out_valid_o       = out_valid_q;
  assign out_symbol_o      = out_sym_q;
  assign out_last_of_run_o = out_last_q;
  assign out_frame_done_o  = out_done_q;

endmodule

@@ hdl/prefix_code_stream_decoder_top.sv @@
// Top level of the prefix code stream decoder: joins controller and datapath.
// Depends on pcsd_pkg, pcsd_ctrl, pcsd_datapath and the assertion macro header.
//
// Table loads and frame header bytes are accepted without leaving the idle
// state, as are bytes that arrive after the frame count is reached. A data
// byte is decoded one bit at a time. A bit that finds the partial code already
// at its maximum length clears it; any other bit scans the code table through
// its single read port from index 0 until the first match. Output stalls can
// hold the emit and flush steps of a data byte. Results leave through an output
// register; the block accepts no new transaction until every symbol of the
// current byte has been handed to that register. No clearing pass follows
// reset.
`include "prefix_code_stream_decoder_top_macros.svh"
module prefix_code_stream_decoder_top import pcsd_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
  parameter int HEADER_BYTES  = DEF_HEADER_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_action_i,
  input  logic [INDEX_W-1:0] in_entry_index_i,
  input  logic [CODE_W-1:0]  in_entry_code_i,
  input  logic [LEN_W-1:0]   in_entry_length_i,
  input  logic [SYM_W-1:0]   in_entry_symbol_i,
  input  logic [BYTE_W-1:0]  in_data_byte_i,
  input  logic               in_last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SYM_W-1:0]   out_symbol_o,
  output logic               out_last_of_run_o,
  output logic               out_frame_done_o
);

  cmd_t    cmd;
  status_t status;

  pcsd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_action_i    (in_action_i),
    .in_last_byte_i (in_last_byte_i),
    .status_i       (status),
    .in_stall_o     (in_stall_o),
    .cmd_o          (cmd)
  );

  pcsd_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .in_entry_index_i  (in_entry_index_i),
    .in_entry_code_i   (in_entry_code_i),
    .in_entry_length_i (in_entry_length_i),
    .in_entry_symbol_i (in_entry_symbol_i),
    .in_data_byte_i    (in_data_byte_i),
    .in_last_byte_i    (in_last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_symbol_o      (out_symbol_o),
    .out_last_of_run_o (out_last_of_run_o),
    .out_frame_done_o  (out_frame_done_o)
  );

  `PCSD_ASSERT(a_done_ends_run, clk_i, rst_ni,
               !out_valid_o || !out_frame_done_o || out_last_of_run_o)
  `PCSD_ASSERT(a_idle_no_pending, clk_i, rst_ni, in_stall_o || !status.pend_valid)
  `PCSD_ASSERT_NEXT(a_load_stays_idle, clk_i, rst_ni,
                    in_valid_i && !in_stall_o && (in_action_i == ACT_LOAD), !in_stall_o)

endmodule
